/* rtl/core/lgg_pkg.sv */
`timescale 1ns / 1ps

package lgg_pkg;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_ADV  = 2'd2;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam int CFG_W = 7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_FIN,
        ST_ADV_LOAD,
        ST_ADV_FIRST,
        ST_ADV_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic clr;
        logic acc_rd;
        logic acc_fin;
        logic adv_start;
        logic adv_first;
        logic adv_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic rows_zero;
        logic adv_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/lgg_ram.sv */
`timescale 1ns / 1ps

module lgg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lgg_ctrl.sv */
`timescale 1ns / 1ps

module lgg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_opcode,
    output logic              o_stall,
    input  lgg_pkg::t_sts     i_sts,
    output lgg_pkg::t_cmd     o_cmd
);

    lgg_pkg::t_state r_state;
    lgg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgg_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            lgg_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = lgg_pkg::ST_IDLE;
                end
            end
            lgg_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_opcode)
                        lgg_pkg::OP_SET,
                        lgg_pkg::OP_READ: n_state = lgg_pkg::ST_ACC_RD;
                        lgg_pkg::OP_ADV: begin
                            n_state = i_sts.rows_zero ? lgg_pkg::ST_DONE
                                                      : lgg_pkg::ST_ADV_LOAD;
                        end
                        default: n_state = lgg_pkg::ST_DONE;
                    endcase
                end
            end
            lgg_pkg::ST_ACC_RD: begin
                o_cmd.acc_rd = 1'b1;
                n_state      = lgg_pkg::ST_ACC_FIN;
            end
            lgg_pkg::ST_ACC_FIN: begin
                o_cmd.acc_fin = 1'b1;
                n_state       = lgg_pkg::ST_DONE;
            end
            lgg_pkg::ST_ADV_LOAD: begin
                o_cmd.adv_start = 1'b1;
                n_state         = lgg_pkg::ST_ADV_FIRST;
            end
            lgg_pkg::ST_ADV_FIRST: begin
                o_cmd.adv_first = 1'b1;
                n_state         = lgg_pkg::ST_ADV_STEP;
            end
            lgg_pkg::ST_ADV_STEP: begin
                o_cmd.adv_step = 1'b1;
                if (i_sts.adv_last) begin
                    n_state = lgg_pkg::ST_DONE;
                end
            end
            lgg_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = lgg_pkg::ST_IDLE;
                end
            end
            default: n_state = lgg_pkg::ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgg_pkg::ST_IDLE) && i_valid |=> (r_state != lgg_pkg::ST_IDLE))
        else $error("accepted item did not start work");

    a_adv_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgg_pkg::ST_ADV_STEP) && !i_sts.adv_last
        |=> (r_state == lgg_pkg::ST_ADV_STEP))
        else $error("advance left before last row");
`endif

endmodule

/* rtl/core/lgg_dpath.sv */
`timescale 1ns / 1ps

module lgg_dpath #(
    parameter int GRID_SIZE = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lgg_pkg::t_cmd                i_cmd,
    output lgg_pkg::t_sts                o_sts,
    input  logic [1:0]                   i_opcode,
    input  logic [5:0]                   i_row,
    input  logic [5:0]                   i_column,
    input  logic                         i_alive,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [lgg_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic                         o_alive_out,
    output logic                         o_out_of_range,
    output logic                         o_ram_we,
    output logic [$clog2(GRID_SIZE)-1:0] o_ram_waddr,
    output logic [GRID_SIZE-1:0]         o_ram_wdata,
    output logic [$clog2(GRID_SIZE)-1:0] o_ram_raddr,
    input  logic [GRID_SIZE-1:0]         i_ram_rdata
);

    localparam int IDX_W = $clog2(GRID_SIZE);
    localparam int CW    = (IDX_W + 1 > lgg_pkg::CFG_W) ? IDX_W + 1 : lgg_pkg::CFG_W;

    logic [lgg_pkg::CFG_W-1:0] r_cols;
    logic [lgg_pkg::CFG_W-1:0] r_rows;
    logic [1:0]                r_op;
    logic [5:0]                r_row;
    logic [5:0]                r_col;
    logic                      r_alive;
    logic                      r_res_alive;
    logic                      r_res_oor;
    logic [CW-1:0]             r_cnt;
    logic [GRID_SIZE-1:0]      r_above;
    logic [GRID_SIZE-1:0]      r_mid;
    logic                      r_out_valid;
    logic                      r_out_alive;
    logic                      r_out_oor;

    logic [CW-1:0]        nr;
    logic [CW-1:0]        nc;
    logic                 in_bad;
    logic [IDX_W-1:0]     col_idx;
    logic [GRID_SIZE-1:0] col_mask;
    logic [GRID_SIZE-1:0] below;
    logic [GRID_SIZE-1:0] ma;
    logic [GRID_SIZE-1:0] mb;
    logic [GRID_SIZE-1:0] mc;
    logic [GRID_SIZE-1:0] rule_row;
    logic [GRID_SIZE-1:0] next_row;
    logic [GRID_SIZE-1:0] set_word;
    logic [3:0]           nbr [GRID_SIZE];

    // active size, saturated at the grid size
    assign nr = (CW'(r_rows) > CW'(GRID_SIZE)) ? CW'(GRID_SIZE) : CW'(r_rows);
    assign nc = (CW'(r_cols) > CW'(GRID_SIZE)) ? CW'(GRID_SIZE) : CW'(r_cols);

    assign in_bad  = (CW'(i_row) >= nr) || (CW'(i_column) >= nc);
    assign col_idx = IDX_W'(r_col);

    always_comb begin
        for (int j = 0; j < GRID_SIZE; j++) begin
            col_mask[j] = (CW'(j) < nc);
        end
    end

    // old row below the current one, dead past the active rows
    assign below = ((r_cnt + CW'(1)) < nr) ? i_ram_rdata : '0;
    assign ma    = r_above & col_mask;
    assign mb    = r_mid & col_mask;
    assign mc    = below & col_mask;

    always_comb begin
        for (int j = 0; j < GRID_SIZE; j++) begin
            nbr[j] = 4'((ma << 1) >> j & GRID_SIZE'(1))
                   + 4'(ma >> j & GRID_SIZE'(1))
                   + 4'((ma >> 1) >> j & GRID_SIZE'(1))
                   + 4'((mb << 1) >> j & GRID_SIZE'(1))
                   + 4'((mb >> 1) >> j & GRID_SIZE'(1))
                   + 4'((mc << 1) >> j & GRID_SIZE'(1))
                   + 4'(mc >> j & GRID_SIZE'(1))
                   + 4'((mc >> 1) >> j & GRID_SIZE'(1));
            rule_row[j] = (nbr[j] == 4'd3) || ((nbr[j] == 4'd2) && mb[j]);
        end
    end

    assign next_row = (rule_row & col_mask) | (r_mid & ~col_mask);

    always_comb begin
        set_word          = i_ram_rdata;
        set_word[col_idx] = r_alive;
    end

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = IDX_W'(r_row);
        o_ram_wdata = set_word;
        priority if (i_cmd.clr) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = IDX_W'(r_cnt);
            o_ram_wdata = '0;
        end else if (i_cmd.adv_step) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = IDX_W'(r_cnt);
            o_ram_wdata = next_row;
        end else if (i_cmd.acc_fin) begin
            o_ram_we = (r_op == lgg_pkg::OP_SET) && !r_res_oor;
        end
    end

    always_comb begin
        o_ram_raddr = '0;
        priority if (i_cmd.acc_rd) begin
            o_ram_raddr = IDX_W'(r_row);
        end else if (i_cmd.adv_first) begin
            o_ram_raddr = IDX_W'(1);
        end else if (i_cmd.adv_step) begin
            o_ram_raddr = IDX_W'(r_cnt + CW'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= lgg_pkg::CFG_W'(64);
            r_rows      <= lgg_pkg::CFG_W'(64);
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lgg_pkg::CFG_COLS: r_cols <= i_cfg_data;
                    lgg_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr || i_cmd.adv_step) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.adv_start) begin
                r_cnt <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op        <= i_opcode;
            r_row       <= i_row;
            r_col       <= i_column;
            r_alive     <= i_alive;
            r_res_alive <= 1'b0;
            r_res_oor   <= in_bad && ((i_opcode == lgg_pkg::OP_SET) ||
                                      (i_opcode == lgg_pkg::OP_READ));
        end
        if (i_cmd.acc_fin) begin
            r_res_alive <= (r_op == lgg_pkg::OP_READ) && !r_res_oor
                           && i_ram_rdata[col_idx];
        end
        if (i_cmd.adv_first) begin
            r_above <= '0;
            r_mid   <= i_ram_rdata;
        end else if (i_cmd.adv_step) begin
            r_above <= r_mid;
            r_mid   <= below;
        end
        if (i_cmd.load_out) begin
            r_out_alive <= r_res_alive;
            r_out_oor   <= r_res_oor;
        end
    end

    assign o_sts.clr_last  = (r_cnt == CW'(GRID_SIZE - 1));
    assign o_sts.rows_zero = (nr == '0);
    assign o_sts.adv_last  = ((r_cnt + CW'(1)) == nr);
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_alive_out    = r_out_alive;
    assign o_out_of_range = r_out_oor;

`ifndef NO_ASSERTIONS
    a_adv_row_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.adv_step && $past(i_cmd.adv_step) |-> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("advance skipped a row");

    a_clear_writes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |-> (o_ram_we && (o_ram_wdata == '0)))
        else $error("clear pass wrote live cells");

    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_alive_out && o_out_of_range))
        else $error("out of range result carries a live cell");
`endif

endmodule

/* rtl/core/life_grid_generation_step.sv */
`timescale 1ns / 1ps
// Set and read: the item goes through ACC_RD and ACC_FIN to DONE, where the result is
// registered once the output is free; no new item is taken before that. Advance: one
// row word read and rewritten per cycle through the grid RAM, for N = min(active_rows,
// GRID_SIZE) rows. No active rows, or the unused opcode: straight to DONE, no grid access.
// Reset (synchronous, active low) sets both sizes to 64 and starts a clear pass that
// zeroes all GRID_SIZE rows of the grid; no item is taken until it ends.
module life_grid_generation_step #(
    parameter int GRID_SIZE = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_opcode,
    input  logic [5:0]                i_row,
    input  logic [5:0]                i_column,
    input  logic                      i_alive,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_alive_out,
    output logic                      o_out_of_range,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [lgg_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(GRID_SIZE);

    lgg_pkg::t_cmd        cmd;
    lgg_pkg::t_sts        sts;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [GRID_SIZE-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [GRID_SIZE-1:0] ram_rdata;

    lgg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_stall  (o_stall),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    lgg_dpath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_opcode),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_alive        (i_alive),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_alive_out    (o_alive_out),
        .o_out_of_range (o_out_of_range),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    lgg_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

/* tb/life_grid_generation_step_test.sv */
`timescale 1ns / 1ps

module life_grid_generation_step_test;

    localparam int GRID = 64;
    localparam logic [1:0] OP_SPARE = 2'd3;

    class life_grid_model;
        typedef struct {
            logic alive;
            logic oor;
        } t_reply;

        logic [GRID-1:0] cells [GRID];
        int unsigned n_rows;
        int unsigned n_cols;
        t_reply expected_replies[$];
        int unsigned mismatches;

        function new();
            foreach (cells[r]) cells[r] = '0;
            n_rows = GRID;
            n_cols = GRID;
            mismatches = 0;
        endfunction

        function void configure(logic idx, logic [lgg_pkg::CFG_W-1:0] value);
            int unsigned eff;
            eff = (value > GRID) ? GRID : value;
            if (idx == lgg_pkg::CFG_COLS) begin
                n_cols = eff;
            end else begin
                n_rows = eff;
            end
        endfunction

        function void next_generation();
            logic [GRID-1:0] prior [GRID];
            int cnt;
            int rr;
            int cc;
            prior = cells;
            for (int r = 0; r < int'(n_rows); r++) begin
                for (int c = 0; c < int'(n_cols); c++) begin
                    cnt = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            rr = r + dr;
                            cc = c + dc;
                            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 &&
                                rr < int'(n_rows) && cc < int'(n_cols)) begin
                                cnt += int'(prior[rr][cc]);
                            end
                        end
                    end
                    cells[r][c] = (cnt == 3) || (cnt == 2 && prior[r][c]);
                end
            end
        endfunction

        function void take_command(logic [1:0] op, logic [5:0] r, logic [5:0] c, logic a);
            t_reply rep;
            logic bad;
            bad = (r >= n_rows) || (c >= n_cols);
            rep.alive = 1'b0;
            rep.oor = 1'b0;
            case (op)
                lgg_pkg::OP_SET: begin
                    rep.oor = bad;
                    if (!bad) cells[r][c] = a;
                end
                lgg_pkg::OP_READ: begin
                    rep.oor = bad;
                    if (!bad) rep.alive = cells[r][c];
                end
                lgg_pkg::OP_ADV: begin
                    next_generation();
                end
                default: ;
            endcase
            expected_replies.push_back(rep);
        endfunction

        function void check_reply(logic alive_out, logic out_of_range);
            t_reply want;
            if (expected_replies.size() == 0) begin
                $error("result with no item pending: alive_out %0b out_of_range %0b",
                       alive_out, out_of_range);
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            if (alive_out !== want.alive) begin
                $error("alive_out: expected %0b, got %0b", want.alive, alive_out);
                mismatches++;
            end
            if (out_of_range !== want.oor) begin
                $error("out_of_range: expected %0b, got %0b", want.oor, out_of_range);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [1:0]                  i_opcode;
    logic [5:0]                  i_row;
    logic [5:0]                  i_column;
    logic                        i_alive;
    logic                        o_valid;
    logic                        i_stall;
    logic                        o_alive_out;
    logic                        o_out_of_range;
    logic                        i_cfg_we;
    logic                        i_cfg_idx;
    logic [lgg_pkg::CFG_W-1:0]   i_cfg_data;

    life_grid_model grid_model = new();
    logic calm;
    int unsigned items_sent;

    life_grid_generation_step dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_alive        (i_alive),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_alive_out    (o_alive_out),
        .o_out_of_range (o_out_of_range),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Called and returns just after a falling edge.
    task automatic send_item(input logic [1:0] op, input logic [5:0] r,
                             input logic [5:0] c, input logic a);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_opcode = op;
        i_row = r;
        i_column = c;
        i_alive = a;
        do @(posedge i_clk); while (o_stall);
        grid_model.take_command(op, r, c, a);
        if (op != OP_SPARE) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                  6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (grid_model.pending() != 0) @(negedge i_clk);
    endtask

    task automatic set_area(input logic [lgg_pkg::CFG_W-1:0] cols,
                            input logic [lgg_pkg::CFG_W-1:0] rows);
        drain();
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = lgg_pkg::CFG_COLS;
        i_cfg_data = cols;
        @(negedge i_clk);
        i_cfg_idx = lgg_pkg::CFG_ROWS;
        i_cfg_data = rows;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        grid_model.configure(lgg_pkg::CFG_COLS, cols);
        grid_model.configure(lgg_pkg::CFG_ROWS, rows);
    endtask

    function automatic logic [lgg_pkg::CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'($urandom_range(65, 127));
            default: return 7'($urandom_range(2, 16));
        endcase
    endfunction

    // Seed a small window, run a few generations and probe the window; with no active area, send noise only.
    task automatic run_episode();
        int unsigned nr;
        int unsigned nc;
        int unsigned span_r;
        int unsigned span_c;
        int unsigned base_r;
        int unsigned base_c;
        nr = grid_model.n_rows;
        nc = grid_model.n_cols;
        calm = ($urandom_range(0, 4) == 0);
        if (nr == 0 || nc == 0) begin
            repeat ($urandom_range(4, 12)) send_noise();
            return;
        end
        span_r = (nr < 8) ? nr : 8;
        span_c = (nc < 8) ? nc : 8;
        base_r = $urandom_range(0, nr - span_r);
        base_c = $urandom_range(0, nc - span_c);
        repeat ($urandom_range(3, 20)) begin
            send_item(lgg_pkg::OP_SET, 6'(base_r + $urandom_range(0, span_r - 1)),
                      6'(base_c + $urandom_range(0, span_c - 1)),
                      1'($urandom_range(0, 3) != 0));
        end
        repeat ($urandom_range(1, 4)) begin
            send_item(lgg_pkg::OP_ADV, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
            repeat ($urandom_range(2, 8)) begin
                send_item(lgg_pkg::OP_READ, 6'(base_r + $urandom_range(0, span_r - 1)),
                          6'(base_c + $urandom_range(0, span_c - 1)),
                          1'($urandom_range(0, 1)));
            end
        end
        repeat ($urandom_range(0, 3)) send_noise();
    endtask

    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm) begin
                int unsigned hold;
                hold = $urandom_range(0, 15);
                if (hold > 0) begin
                    i_stall = 1'b1;
                    repeat (hold) @(negedge i_clk);
                    i_stall = 1'b0;
                end
            end
            do @(posedge i_clk); while (!o_valid);
            grid_model.check_reply(o_alive_out, o_out_of_range);
        end
    end

    initial begin
        logic [lgg_pkg::CFG_W-1:0] fixed_cols [8];
        logic [lgg_pkg::CFG_W-1:0] fixed_rows [8];
        int unsigned phase;
        int unsigned phase_end;
        fixed_cols = '{7'd64, 7'd1, 7'd0, 7'd9, 7'd127, 7'd65, 7'd16, 7'd64};
        fixed_rows = '{7'd64, 7'd1, 7'd12, 7'd0, 7'd127, 7'd5, 7'd64, 7'd16};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = lgg_pkg::OP_SET;
        i_row = '0;
        i_column = '0;
        i_alive = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = lgg_pkg::CFG_COLS;
        i_cfg_data = '0;
        calm = 1'b0;
        items_sent = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners, a blinker, the spare opcode
        send_item(lgg_pkg::OP_SET, 6'd0, 6'd0, 1'b1);
        send_item(lgg_pkg::OP_SET, 6'd63, 6'd63, 1'b1);
        send_item(lgg_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
        send_item(lgg_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
        send_item(lgg_pkg::OP_SET, 6'd10, 6'd20, 1'b1);
        send_item(lgg_pkg::OP_SET, 6'd10, 6'd21, 1'b1);
        send_item(lgg_pkg::OP_SET, 6'd10, 6'd22, 1'b1);
        drain();
        send_item(lgg_pkg::OP_ADV, 6'd0, 6'd0, 1'b0);
        send_item(lgg_pkg::OP_READ, 6'd9, 6'd21, 1'b0);
        send_item(lgg_pkg::OP_READ, 6'd11, 6'd21, 1'b0);
        send_item(lgg_pkg::OP_READ, 6'd10, 6'd20, 1'b0);
        send_item(OP_SPARE, 6'd63, 6'd63, 1'b1);
        send_item(lgg_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
        send_item(lgg_pkg::OP_ADV, 6'd63, 6'd63, 1'b1);
        send_item(lgg_pkg::OP_READ, 6'd10, 6'd22, 1'b1);
        send_item(lgg_pkg::OP_SET, 6'd10, 6'd21, 1'b0);
        // no active area
        set_area(7'd0, 7'd0);
        send_item(lgg_pkg::OP_SET, 6'd0, 6'd0, 1'b1);
        send_item(lgg_pkg::OP_READ, 6'd10, 6'd20, 1'b0);
        send_item(lgg_pkg::OP_ADV, 6'd0, 6'd0, 1'b0);
        // partial area: edges and outside cells kept by advance
        set_area(7'd12, 7'd11);
        send_item(lgg_pkg::OP_SET, 6'd11, 6'd0, 1'b1);
        send_item(lgg_pkg::OP_READ, 6'd0, 6'd12, 1'b0);
        send_item(lgg_pkg::OP_READ, 6'd10, 6'd11, 1'b0);
        send_item(lgg_pkg::OP_ADV, 6'd0, 6'd0, 1'b0);
        set_area(7'd127, 7'd127);
        send_item(lgg_pkg::OP_READ, 6'd9, 6'd21, 1'b0);
        send_item(lgg_pkg::OP_READ, 6'd63, 6'd63, 1'b0);

        phase = 0;
        while (items_sent < 1220) begin
            if (phase < 8) begin
                set_area(fixed_cols[phase], fixed_rows[phase]);
            end else begin
                set_area(pick_size(), pick_size());
            end
            phase_end = items_sent + 120;
            while (items_sent < phase_end && items_sent < 1220) run_episode();
            phase++;
        end

        calm = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);
        if (grid_model.mismatches == 0 && grid_model.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
